FILE: rtl/assert_macros.svh
// Assertion macros for RTL that checks itself; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/rost_pkg.sv
// Types and constants of the reliable ordered sequence tracker.
package rost_pkg;

    localparam logic [2:0] V_UNTRACKED = 3'd0;
    localparam logic [2:0] V_INORDER   = 3'd1;
    localparam logic [2:0] V_RETRANS   = 3'd2;
    localparam logic [2:0] V_DUP       = 3'd3;
    localparam logic [2:0] V_GAP       = 3'd4;
    localparam logic [2:0] V_KICK      = 3'd5;

    localparam logic [1:0] REG_BASE_TYPE = 2'd0;
    localparam logic [1:0] REG_MAX_DUPS  = 2'd1;
    localparam logic [1:0] REG_DUP_DECAY = 2'd2;

    localparam logic [7:0]  RST_BASE_TYPE = 8'd67;
    localparam logic [15:0] RST_MAX_DUPS  = 16'd1000;
    localparam logic [7:0]  RST_DUP_DECAY = 8'd10;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [15:0] seq_num;
    } t_in;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        ack_valid;
        logic [7:0]  ack_type;
        logic [6:0]  ack_seq_low;
        logic [6:0]  ack_seq_high;
        logic [15:0] dup_count_out;
        logic        missing_overflow;
    } t_out;

    typedef struct packed {
        logic load;
        logic classify;
        logic scan_rd;
        logic scan_cmp;
        logic resolve;
        logic gap_step;
    } t_cmd;

    typedef struct packed {
        logic tracked;
        logic is_old;
        logic is_gap;
        logic scan_last;
        logic gap_done;
    } t_status;

endpackage

FILE: rtl/rost_ctrl.sv
// Controller state machine of the sequence tracker.
module rost_ctrl import rost_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_valid
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CLASSIFY = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CMP = 7'b0001000,
        S_RESOLVE  = 7'b0010000,
        S_GAP      = 7'b0100000,
        S_FINISH   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                o_cmd.classify = 1'b1;
                if (!i_status.tracked) begin
                    n_state = S_FINISH;
                end else if (i_status.is_old) begin
                    n_state = S_SCAN_RD;
                end else if (i_status.is_gap) begin
                    n_state = S_GAP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = i_status.scan_last ? S_RESOLVE : S_SCAN_RD;
            end
            S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = S_FINISH;
            end
            S_GAP: begin
                o_cmd.gap_step = 1'b1;
                if (i_status.gap_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_FINISH);

endmodule

FILE: rtl/rost_dp.sv
// Datapath of the sequence tracker: registers, channel state and missing table.
module rost_dp import rost_pkg::*; #(
    parameter int CHANNELS      = 32,
    parameter int MISSING_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  t_in         i_in,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output t_out        o_out
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = $clog2(MISSING_DEPTH);
    localparam logic [AW-1:0] K_LAST  = AW'(MISSING_DEPTH - 1);
    localparam logic [AW:0]   S_FULL  = (AW+1)'(MISSING_DEPTH);
    localparam logic [8:0]    CH_CNT  = 9'(CHANNELS);

    logic [7:0]  r_base, r_decay;
    logic [15:0] r_max_dups;
    logic [7:0]  r_type;
    logic [15:0] r_seq;
    logic [15:0] r_dup;
    logic [2:0]  r_verdict;
    logic        r_ovf;
    logic        r_hit;
    logic [CW-1:0] r_ch;
    logic [AW-1:0] r_k;
    logic [AW:0]   r_slot;
    logic [16:0]   r_s;
    logic [15:0] r_last [CHANNELS];
    logic [MISSING_DEPTH-1:0] r_mvalid;
    logic [20:0] r_mem [MISSING_DEPTH];
    logic [20:0] r_rd;

    logic [8:0]    diff;
    logic [CW-1:0] ch;
    logic [15:0]   last;
    logic          tracked, is_old, is_gap;
    logic [15:0]   dup_inc;
    logic [15:0]   dup_dec;
    logic          ack;

    assign diff    = {1'b0, r_type} - {1'b0, r_base};
    assign tracked = (r_type >= r_base) && (diff < CH_CNT);
    assign ch      = diff[CW-1:0];
    assign last    = r_last[ch];
    assign is_old  = (r_seq <= last) && (last != 16'd0);
    assign is_gap  = {1'b0, r_seq} > ({1'b0, last} + 17'd2);
    assign dup_inc = (r_dup != 16'hFFFF) ? r_dup + 16'd1 : r_dup;
    assign dup_dec = (r_dup > {8'd0, r_decay}) ? r_dup - {8'd0, r_decay} : 16'd0;

    assign o_status.tracked   = tracked;
    assign o_status.is_old    = is_old;
    assign o_status.is_gap    = is_gap;
    assign o_status.scan_last = (r_k == K_LAST);
    assign o_status.gap_done  = (r_s >= {1'b0, r_seq}) || (r_slot == S_FULL);

    // Configuration registers, channel last numbers, duplicate count and missing table valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= RST_BASE_TYPE;
            r_max_dups <= RST_MAX_DUPS;
            r_decay    <= RST_DUP_DECAY;
            r_dup      <= '0;
            r_mvalid   <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE_TYPE: r_base     <= i_cfg_data[7:0];
                    REG_MAX_DUPS:  r_max_dups <= i_cfg_data;
                    REG_DUP_DECAY: r_decay    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.classify && tracked && !is_old) begin
                r_last[ch] <= r_seq;
                if (!is_gap) begin
                    r_dup <= dup_dec;
                end
            end
            if (i_cmd.scan_cmp && r_mvalid[r_k] && (r_rd[20:16] == 5'(r_ch))
                    && (r_rd[15:0] == r_seq)) begin
                r_mvalid[r_k] <= 1'b0;
            end
            if (i_cmd.resolve && !r_hit) begin
                r_dup <= dup_inc;
            end
            if (i_cmd.gap_step && !o_status.gap_done && !r_mvalid[r_slot[AW-1:0]]) begin
                r_mvalid[r_slot[AW-1:0]] <= 1'b1;
            end
        end
    end

    // Item registers and sequencing counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_in.msg_type;
            r_seq  <= i_in.seq_num;
        end
        if (i_cmd.classify) begin
            r_ch   <= ch;
            r_k    <= '0;
            r_slot <= '0;
            r_s    <= {1'b0, last} + 17'd2;
            r_hit  <= 1'b0;
            r_ovf  <= 1'b0;
            if (!tracked) begin
                r_verdict <= V_UNTRACKED;
            end else if (is_old) begin
                r_verdict <= V_DUP;
            end else if (is_gap) begin
                r_verdict <= V_GAP;
            end else begin
                r_verdict <= V_INORDER;
            end
        end
        if (i_cmd.scan_cmp) begin
            r_k <= r_k + AW'(1);
            if (r_mvalid[r_k] && (r_rd[20:16] == 5'(r_ch)) && (r_rd[15:0] == r_seq)) begin
                r_hit <= 1'b1;
            end
        end
        if (i_cmd.resolve) begin
            if (r_hit) begin
                r_verdict <= V_RETRANS;
            end else if (dup_inc >= r_max_dups) begin
                r_verdict <= V_KICK;
            end else begin
                r_verdict <= V_DUP;
            end
        end
        if (i_cmd.gap_step && !o_status.gap_done) begin
            if (r_mvalid[r_slot[AW-1:0]]) begin
                r_slot <= r_slot + (AW+1)'(1);
            end else begin
                r_slot <= r_slot + (AW+1)'(1);
                r_s    <= r_s + 17'd2;
            end
        end
        if (i_cmd.gap_step && (r_s < {1'b0, r_seq}) && (r_slot == S_FULL)) begin
            r_ovf <= 1'b1;
        end
    end

    // Missing table payload memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.gap_step && !o_status.gap_done && !r_mvalid[r_slot[AW-1:0]]) begin
            r_mem[r_slot[AW-1:0]] <= {5'(r_ch), r_s[15:0]};
        end
        if (i_cmd.scan_rd) begin
            r_rd <= r_mem[r_k];
        end
    end

    assign ack = (r_verdict != V_UNTRACKED) && (r_verdict != V_KICK);

    assign o_out.verdict          = r_verdict;
    assign o_out.ack_valid        = ack;
    assign o_out.ack_type         = ack ? r_type : 8'd0;
    assign o_out.ack_seq_low      = ack ? r_seq[7:1] : 7'd0;
    assign o_out.ack_seq_high     = ack ? r_seq[15:9] : 7'd0;
    assign o_out.dup_count_out    = r_dup;
    assign o_out.missing_overflow = r_ovf;

endmodule

FILE: rtl/reliable_ordered_seq_tracker_unit.sv
// Top level of the reliable ordered sequence tracker.
//
// Usage: raise i_start with a message type and sequence number on i_in; the
// item is taken at a clock edge where i_start is high and o_busy is low.
// Exactly one result item follows on o_out, marked by o_valid for a single
// cycle; the receiver has no way to hold it off, so it must take it then.
// Steps from the accepting edge to the result cycle:
//   untracked and in-order items: classify, then result;
//   old numbers: classify, then a walk of the whole missing table memory
//   through its single read port, each entry read and then compared, then
//   resolve and result; gaps: classify, then table slots probed in turn
//   while recording the skipped numbers (at most MISSING_DEPTH), then result.
// One item is in flight at a time; o_busy stays high until the result cycle
// ends, so the next item is taken only once the block is back in idle. The
// configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes a register at
// any edge with the write enable high, indexes above 2 do nothing.
// Reset restores the register defaults, clears every channel's last number,
// the duplicate count and all missing table valid bits together; there
// is no clearing pass.
module reliable_ordered_seq_tracker_unit import rost_pkg::*; #(
    parameter int CHANNELS      = 32,
    parameter int MISSING_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in         i_in,
    output logic        o_busy,
    output logic        o_valid,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

`include "assert_macros.svh"

    t_cmd    cmd;
    t_status status;

    // The controller sequences each item; the datapath holds all item and table state.
    rost_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    rost_dp #(
        .CHANNELS      (CHANNELS),
        .MISSING_DEPTH (MISSING_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out      (o_out)
    );

    // An accepted item is followed by a working cycle, never a result at once.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy && !o_valid)
    // A result lasts a single cycle and frees the block.
    `ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid && !o_busy)
    // A kick never carries an acknowledge.
    `ASSERT_IMPLIES(a_kick_noack, i_clk, i_rst_n, o_valid && (o_out.verdict == V_KICK),
        !o_out.ack_valid)
    // Only gap items can report an overflow of the missing table.
    `ASSERT_IMPLIES(a_ovf_gap, i_clk, i_rst_n, o_valid && o_out.missing_overflow,
        o_out.verdict == V_GAP)

endmodule
